@@ hdl/lsbs_pkg.sv @@
// ---------------------------------------------------------------------------
// lsbs_pkg: shared types and constants of the log spectrum bar smoother
// Fixed widths, the log2 interpolation table, CSR codes and the sequencer
// state type.
// ---------------------------------------------------------------------------
package lsbs_pkg;

   // field widths
   localparam int MAG_W      = 16;
   localparam int HEIGHT_W   = 10;
   localparam int BIN_IDX_W  = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // datapath widths
   localparam int ENERGY_W = 26;   // mag (15 bit) * (i+1) (11 bit)
   localparam int X_W      = 32;   // log2 argument, normalized to bit 31
   localparam int POS_W    = 5;    // leading-one position
   localparam int LOG_W    = 21;   // log2 in Q16, below 26.0
   localparam int DIFF_W   = 13;   // neighbor table step
   localparam int FRAC_T_W = 12;   // interpolation fraction
   localparam int MUL_A_W  = 37;
   localparam int MUL_B_W  = 16;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

   // fixed-point scales
   localparam int LOG_FRAC_W  = 16;
   localparam int GAIN_FRAC_W = 8;
   localparam int LN2_FRAC_W  = 16;
   localparam logic [MUL_B_W-1:0] LN2_Q16 = 16'd45426;

   // floor(x/3) = (x * RECIP3) >> RECIP3_SHIFT, exact for x below 2^16
   localparam logic [MUL_B_W-1:0] RECIP3 = 16'd43691;
   localparam int RECIP3_SHIFT = 17;

   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 10'd1023;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] KNEE_RESET = 16'd10495;
   localparam logic [CSR_DATA_W-1:0] GAIN_RESET = 16'd23135;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_KNEE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_GAIN = 4'd1;

   // round(65536*log2(1+k/16)), k = 0..16
   localparam logic [16:0] LOG2_TAB [17] = '{
      17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
      17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
      17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
   };

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,    // sweep the height store after reset
      ST_IDLE,     // wait for a word
      ST_ENERGY,   // energy + knee into the normalizer
      ST_NORM,     // shift to the leading one
      ST_INTERP,   // table step times fraction
      ST_LOGSUM,   // assemble log2
      ST_GAIN,     // d * gain
      ST_LN2,      // (d * gain) * ln2
      ST_LEVEL,    // scale and saturate level
      ST_MIX,      // neighbor mix, divide by 3 via reciprocal
      ST_DIV,      // final height
      ST_DONE      // write back and hand off result
   } lsbs_state_type;

endpackage

@@ hdl/lsbs_ifs.sv @@
// ---------------------------------------------------------------------------
// lsbs channel interfaces
// Valid/ready channels for bin words, result words and register writes.
// ---------------------------------------------------------------------------
interface lsbs_req_if;
   import lsbs_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [MAG_W-1:0]  magnitude;
   logic                     frame_start;

   modport source (output valid, magnitude, frame_start, input ready);
   modport sink   (input valid, magnitude, frame_start, output ready);
endinterface

interface lsbs_rsp_if;
   import lsbs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [HEIGHT_W-1:0]   bar_height;
   logic [BIN_IDX_W-1:0]  bin_index;
   logic                  last_bin;

   modport source (output valid, bar_height, bin_index, last_bin, input ready);
   modport sink   (input valid, bar_height, bin_index, last_bin, output ready);
endinterface

interface lsbs_csr_if;
   import lsbs_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/log_spectrum_bar_smoother_top.sv @@
// ---------------------------------------------------------------------------
// log_spectrum_bar_smoother_top: log-scaled spectrum bar smoother
// Maps each bin magnitude to a log level, mixes it with neighbor heights
// and smooths it against the stored height of the bin.
//
//   channel  | dir | payload                               | accepted when
//   ---------+-----+---------------------------------------+----------------
//   req_bus  | in  | magnitude, frame_start                | valid & ready
//   rsp_bus  | out | bar_height, bin_index, last_bin       | valid & ready
//   csr_bus  | in  | index, data (0 log_knee, 1 log_gain)  | valid & ready
//
// The time per word varies with the leading-one normalizer (8 or 1 bit
// per cycle), which runs twice per word (energy + knee, then knee); the
// shared 37x16 multiplier is used six times per word at fixed steps. A new
// word is taken only in the idle state, once the last one is written back.
// After reset the height store is swept to zero; req_bus is not ready
// meanwhile. Register writes are always taken.
// A finished word waits in the output register; the next word is taken
// while it waits, and write-back stalls only if the register is still full.
// ---------------------------------------------------------------------------
module log_spectrum_bar_smoother_top #(
   parameter int NUM_BINS        = 256,
   parameter int LEVEL_FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   lsbs_req_if.sink    req_bus,
   lsbs_rsp_if.source  rsp_bus,
   lsbs_csr_if.sink    csr_bus
);
   import lsbs_pkg::*;

   localparam int AW     = (NUM_BINS > 2) ? $clog2(NUM_BINS) : 1;
   localparam int LW     = 10 + LEVEL_FRAC_BITS;      // level width
   localparam int NW     = 14 + LEVEL_FRAC_BITS;      // mix sum width
   localparam int LV_LSB = LOG_FRAC_W + GAIN_FRAC_W + LN2_FRAC_W - LEVEL_FRAC_BITS;
   localparam int LV_TOP = LV_LSB + LW;
   localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BINS - 1);

   // control state
   lsbs_state_type state_ff, state_in;
   logic [AW-1:0]          cnt_ff;
   logic [AW-1:0]          clr_ff;
   logic                   pass_ff;
   logic [HEIGHT_W-1:0]    left_ff;
   logic [CSR_DATA_W-1:0]  knee_ff;
   logic [CSR_DATA_W-1:0]  gain_ff;
   logic                   rsp_valid_ff;

   // datapath
   logic [AW-1:0]          idx_ff;
   logic [MUL_P_W-1:0]     mul_p_ff;
   logic [X_W-1:0]         x_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [LOG_W-1:0]       lx_ff;
   logic [LOG_W-1:0]       d_ff;
   logic [LW-1:0]          lv_ff;
   logic [HEIGHT_W-1:0]    old_ff;
   logic [HEIGHT_W-1:0]    right_ff;
   logic [HEIGHT_W-1:0]    h_ff;
   logic [HEIGHT_W-1:0]    bar_height_ff;
   logic [BIN_IDX_W-1:0]   bin_index_ff;
   logic                   last_bin_ff;

   // height store
   logic [HEIGHT_W-1:0]    mem [NUM_BINS];
   logic [HEIGHT_W-1:0]    rd_data_ff;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          wr_addr;
   logic [HEIGHT_W-1:0]    wr_data;
   logic                   wr_en;

   // combinational helpers
   logic                   req_take;
   logic                   out_free;
   logic [AW-1:0]          idx_next;
   logic [AW-1:0]          idx_succ;
   logic                   idx_last;
   logic [CSR_DATA_W-1:0]  knee_eff;
   logic [MUL_A_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]     mul_b;
   logic [MUL_P_W-1:0]     mul_p_in;
   logic [3:0]             tab_k;
   logic [FRAC_T_W-1:0]    tab_t;
   logic [16:0]            tab_lo;
   logic [16:0]            tab_hi;
   logic [DIFF_W-1:0]      tab_diff;
   logic [LOG_W-1:0]       log_val;
   logic [NW-1:0]          old_sh;
   logic [NW-1:0]          left_v;
   logic [NW-1:0]          right_v;
   logic [NW-1:0]          num;
   logic [13:0]            n2;
   logic [11:0]            n3;
   logic [10:0]            quo;

   assign req_take = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign idx_next = req_bus.frame_start ? '0 : cnt_ff;
   assign idx_last = (idx_ff == LAST_IDX);
   assign idx_succ = idx_last ? '0 : idx_ff + AW'(1);
   assign knee_eff = (knee_ff == '0) ? CSR_DATA_W'(1) : knee_ff;

   // log2 table lookup on the normalized argument
   assign tab_k    = x_ff[30:27];
   assign tab_t    = x_ff[26:15];
   assign tab_lo   = LOG2_TAB[{1'b0, tab_k}];
   assign tab_hi   = LOG2_TAB[{1'b0, tab_k} + 5'd1];
   assign tab_diff = DIFF_W'(tab_hi - tab_lo);
   assign log_val  = {pos_ff, {LOG_FRAC_W{1'b0}}} + LOG_W'(tab_lo)
                   + LOG_W'(mul_p_ff[FRAC_T_W+DIFF_W-1:FRAC_T_W]);

   // neighbor mix, heights aligned to the level's fraction
   assign old_sh  = NW'(old_ff) << LEVEL_FRAC_BITS;
   assign left_v  = (idx_ff == '0) ? NW'(lv_ff) : (NW'(left_ff) << LEVEL_FRAC_BITS);
   assign right_v = idx_last ? NW'(lv_ff) : (NW'(right_ff) << LEVEL_FRAC_BITS);
   assign num     = (old_sh << 3) + (NW'(lv_ff) << 1) + left_v + right_v;
   assign n2      = num[NW-1:LEVEL_FRAC_BITS];
   assign n3      = n2[13:2];
   assign quo     = mul_p_ff[RECIP3_SHIFT+10:RECIP3_SHIFT];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == LAST_IDX) state_in = ST_IDLE;
         ST_IDLE:   if (req_take) state_in = ST_ENERGY;
         ST_ENERGY: state_in = ST_NORM;
         ST_NORM:   if (x_ff[X_W-1]) state_in = ST_INTERP;
         ST_INTERP: state_in = ST_LOGSUM;
         ST_LOGSUM: state_in = pass_ff ? ST_GAIN : ST_NORM;
         ST_GAIN:   state_in = ST_LN2;
         ST_LN2:    state_in = ST_LEVEL;
         ST_LEVEL:  state_in = ST_MIX;
         ST_MIX:    state_in = ST_DIV;
         ST_DIV:    state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs: handshake, store port and multiplier operands
   always_comb begin
      req_bus.ready = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = h_ff;
      rd_addr       = idx_last ? idx_ff : idx_ff + AW'(1);
      mul_a         = '0;
      mul_b         = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            rd_addr       = idx_next;
            mul_a = req_bus.magnitude[MAG_W-1] ? '0 : MUL_A_W'(req_bus.magnitude[MAG_W-2:0]);
            mul_b = MUL_B_W'(idx_next) + MUL_B_W'(1);
         end
         ST_INTERP: begin
            mul_a = MUL_A_W'(tab_diff);
            mul_b = MUL_B_W'(tab_t);
         end
         ST_GAIN: begin
            mul_a = MUL_A_W'(d_ff);
            mul_b = gain_ff;
         end
         ST_LN2: begin
            mul_a = mul_p_ff[MUL_A_W-1:0];
            mul_b = LN2_Q16;
         end
         ST_MIX: begin
            mul_a = MUL_A_W'(n3);
            mul_b = RECIP3;
         end
         ST_DONE: wr_en = out_free;
         default: ;
      endcase
   end

   assign mul_p_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         pass_ff      <= 1'b0;
         left_ff      <= '0;
         knee_ff      <= KNEE_RESET;
         gain_ff      <= GAIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (state_ff == ST_ENERGY) pass_ff <= 1'b0;
         if (state_ff == ST_LOGSUM) pass_ff <= 1'b1;
         if (csr_bus.valid) begin
            unique case (csr_bus.index)
               CSR_LOG_KNEE: knee_ff <= csr_bus.data;
               CSR_LOG_GAIN: gain_ff <= csr_bus.data;
               default: ;
            endcase
         end
         if (state_ff == ST_DONE && out_free) begin
            left_ff      <= h_ff;
            cnt_ff       <= idx_succ;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mul_p_ff <= mul_p_in;
      case (state_ff)
         ST_IDLE: idx_ff <= idx_next;
         ST_ENERGY: begin
            old_ff <= rd_data_ff;
            x_ff   <= X_W'(mul_p_ff[ENERGY_W-1:0]) + X_W'(knee_eff);
            pos_ff <= POS_W'(X_W - 1);
         end
         ST_NORM: begin
            right_ff <= rd_data_ff;
            if (!x_ff[X_W-1]) begin
               if (x_ff[X_W-1:X_W-8] == '0) begin
                  x_ff   <= x_ff << 8;
                  pos_ff <= pos_ff - POS_W'(8);
               end else begin
                  x_ff   <= x_ff << 1;
                  pos_ff <= pos_ff - POS_W'(1);
               end
            end
         end
         ST_LOGSUM: begin
            if (!pass_ff) begin
               lx_ff  <= log_val;
               x_ff   <= X_W'(knee_eff);
               pos_ff <= POS_W'(X_W - 1);
            end else begin
               d_ff <= (lx_ff > log_val) ? lx_ff - log_val : '0;
            end
         end
         ST_LEVEL: begin
            lv_ff <= (|mul_p_ff[MUL_P_W-1:LV_TOP]) ? {LW{1'b1}}
                                                  : mul_p_ff[LV_TOP-1:LV_LSB];
         end
         ST_DIV: h_ff <= (quo > 11'(HEIGHT_MAX)) ? HEIGHT_MAX : quo[HEIGHT_W-1:0];
         ST_DONE: begin
            if (out_free) begin
               bar_height_ff <= h_ff;
               bin_index_ff  <= BIN_IDX_W'(idx_ff);
               last_bin_ff   <= idx_last;
            end
         end
         default: ;
      endcase
   end

   // height store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.bar_height = bar_height_ff;
   assign rsp_bus.bin_index  = bin_index_ff;
   assign rsp_bus.last_bin   = last_bin_ff;

endmodule

@@ sim/tb_log_spectrum_bar_smoother_top.sv @@
// ---------------------------------------------------------------------------
// tb_log_spectrum_bar_smoother_top: self-checking bench for the bar smoother
// Streams spectrum bins through the block over several knee/gain settings,
// predicts every bar height in the bench itself and checks each result word
// field by field against the oldest prediction. Both sides idle in random
// bursts; once the receiver holds off long enough to back up the input.
// ---------------------------------------------------------------------------
module tb_log_spectrum_bar_smoother_top;
   import lsbs_pkg::*;

   localparam int NUM_BINS        = 256;
   localparam int LEVEL_FRAC_BITS = 8;
   localparam int WATCHDOG_LIMIT  = 5000;   // cycles with no handshake at all
   localparam int LONG_HOLD       = 300;
   localparam int TAIL_CYCLES     = 80;

   typedef struct {
      logic signed [MAG_W-1:0] mag;
      logic                    fs;
   } bin_word_type;

   typedef struct {
      logic [HEIGHT_W-1:0]  height;
      logic [BIN_IDX_W-1:0] bin;
      logic                 is_last;
   } bar_word_type;

   logic clock;
   logic reset;

   lsbs_req_if req_bus ();
   lsbs_rsp_if rsp_bus ();
   lsbs_csr_if csr_bus ();

   log_spectrum_bar_smoother_top #(
      .NUM_BINS        (NUM_BINS),
      .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // bench copy of the block state
   logic [HEIGHT_W-1:0] shadow_heights [NUM_BINS];
   int unsigned         bin_ctr = 0;
   longint unsigned     left_h = 0;
   longint unsigned     knee_reg = KNEE_RESET;
   longint unsigned     gain_reg = GAIN_RESET;

   bin_word_type bins_to_send [$];
   bar_word_type heights_due [$];

   int   err_count = 0;
   int   idle_cycles = 0;
   logic req_taken = 1'b0;
   logic idle_en = 1'b1;
   logic hold_arm = 1'b0;
   logic hold_used = 1'b0;
   int   hold_left = 0;
   int   tx_gap = 0, tx_quiet = 0, rx_gap = 0, rx_quiet = 0;
   int unsigned tx_roll, rx_roll;
   bin_word_type nxt;
   bar_word_type got, want;
   logic progress;

   initial begin
      for (int b = 0; b < NUM_BINS; b++) shadow_heights[b] = '0;
   end

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // known values on every input from time zero
   initial begin
      req_bus.valid       = 1'b0;
      req_bus.magnitude   = '0;
      req_bus.frame_start = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = '0;
      csr_bus.data        = '0;
   end

   // log2 in Q16: leading-one position plus interpolated table fraction
   function automatic longint unsigned log2_fix(input logic [31:0] x);
      int unsigned     pos;
      logic [31:0]     norm;
      logic [15:0]     frac;
      int unsigned     k;
      longint unsigned lo, hi, t;
      pos = 0;
      for (int b = 0; b < 32; b++) if (x[b]) pos = b;
      norm = x << (31 - pos);
      frac = norm[30:15];
      k = frac[15:12];
      t = frac[11:0];
      lo = LOG2_TAB[k];
      hi = LOG2_TAB[k + 1];
      return (longint'(pos) << 16) + lo + (((hi - lo) * t) >> 12);
   endfunction

   // level = gain * ln(1 + e/knee), fixed point, saturated
   function automatic longint unsigned bar_level(input longint unsigned energy);
      longint unsigned kn, lx, lk, d, lv, lmax;
      kn = (knee_reg == 0) ? 1 : knee_reg;
      lx = log2_fix(32'(energy + kn));
      lk = log2_fix(32'(kn));
      d = (lx > lk) ? lx - lk : 0;
      lv = (gain_reg * d * LN2_Q16) >> (40 - LEVEL_FRAC_BITS);
      lmax = (64'd1 << (10 + LEVEL_FRAC_BITS)) - 1;
      return (lv > lmax) ? lmax : lv;
   endfunction

   // next bar height for one bin word; advances the bench state
   function automatic bar_word_type predict_bar(input logic signed [MAG_W-1:0] mag_in,
                                                input logic fs);
      longint unsigned mag, idx, lv, old_h, left, right, num, h;
      bar_word_type w;
      mag = mag_in[MAG_W-1] ? 0 : mag_in[MAG_W-2:0];
      if (fs) bin_ctr = 0;
      if (bin_ctr >= NUM_BINS) bin_ctr = 0;
      idx = bin_ctr;
      lv = bar_level(mag * (idx + 1));
      old_h = longint'(shadow_heights[idx]) << LEVEL_FRAC_BITS;
      // edge bins take the level for the missing neighbor
      left = (idx == 0) ? lv : (left_h << LEVEL_FRAC_BITS);
      right = (idx == NUM_BINS - 1) ? lv
            : (longint'(shadow_heights[idx + 1]) << LEVEL_FRAC_BITS);
      num = 8 * old_h + 2 * lv + left + right;
      h = num / (64'd12 << LEVEL_FRAC_BITS);
      if (h > HEIGHT_MAX) h = HEIGHT_MAX;
      shadow_heights[idx] = h[HEIGHT_W-1:0];
      left_h = h;
      bin_ctr = (idx + 1 >= NUM_BINS) ? 0 : idx + 1;
      w.height  = h[HEIGHT_W-1:0];
      w.bin     = idx[BIN_IDX_W-1:0];
      w.is_last = (idx == NUM_BINS - 1);
      return w;
   endfunction

   task automatic log_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      err_count++;
   endtask

   // accept side: predictions, register updates and result checks
   always @(posedge clock) begin
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         progress = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            progress = 1'b1;
            got.height  = rsp_bus.bar_height;
            got.bin     = rsp_bus.bin_index;
            got.is_last = rsp_bus.last_bin;
            if (heights_due.size() == 0) begin
               log_mismatch($sformatf("unexpected word, bin %0d height %0d",
                                      got.bin, got.height));
            end else begin
               want = heights_due.pop_front();
               if (got.height !== want.height)
                  log_mismatch($sformatf("bin %0d: bar_height %0d, expected %0d",
                                         want.bin, got.height, want.height));
               if (got.bin !== want.bin)
                  log_mismatch($sformatf("bin_index %0d, expected %0d",
                                         got.bin, want.bin));
               if (got.is_last !== want.is_last)
                  log_mismatch($sformatf("bin %0d: last_bin %0b, expected %0b",
                                         want.bin, got.is_last, want.is_last));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            progress = 1'b1;
            heights_due.push_back(predict_bar(req_bus.magnitude, req_bus.frame_start));
         end
         if (csr_bus.valid && csr_bus.ready) begin
            progress = 1'b1;
            unique case (csr_bus.index)
               CSR_LOG_KNEE: knee_reg = csr_bus.data;
               CSR_LOG_GAIN: gain_reg = csr_bus.data;
               default: ;
            endcase
         end
         req_taken   <= req_bus.valid && req_bus.ready;
         idle_cycles <= progress ? 0 : idle_cycles + 1;
      end
   end

   // bin word driver, fed from the pending queue
   always @(negedge clock) begin
      if (!req_bus.valid || req_taken) begin
         if (tx_gap != 0) begin
            tx_gap        <= tx_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (bins_to_send.size() != 0) begin
            nxt = bins_to_send.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.magnitude   <= nxt.mag;
            req_bus.frame_start <= nxt.fs;
            if (tx_quiet != 0) begin
               tx_quiet <= tx_quiet - 1;
            end else if (idle_en) begin
               tx_roll = $urandom_range(0, 99);
               if (tx_roll < 15) tx_gap <= $urandom_range(1, 6);
               else if (tx_roll < 18) tx_quiet <= $urandom_range(20, 60);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (hold_arm && !hold_used) begin
         hold_used     <= 1'b1;
         hold_left     <= LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rx_gap != 0) begin
         rx_gap        <= rx_gap - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (rx_quiet != 0) begin
            rx_quiet <= rx_quiet - 1;
         end else if (idle_en) begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 12) rx_gap <= $urandom_range(1, 6);
            else if (rx_roll < 14) rx_quiet <= $urandom_range(30, 80);
         end
      end
   end

   // watchdog: no handshake of any kind for too long
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic queue_bin(input logic signed [MAG_W-1:0] m, input logic f);
      bin_word_type w;
      w.mag = m;
      w.fs  = f;
      bins_to_send.push_back(w);
   endtask

   function automatic logic signed [MAG_W-1:0] pick_magnitude();
      int unsigned roll;
      logic [31:0] raw;
      roll = $urandom_range(0, 99);
      raw  = $urandom;
      if (roll < 45) return raw[MAG_W-1:0];
      if (roll < 65) return MAG_W'($urandom_range(0, 255));
      if (roll < 85) return MAG_W'($urandom_range(16384, 32767));
      return {1'b1, raw[MAG_W-2:0]};
   endfunction

   // mostly whole frames; some cut short, some running on past the last bin,
   // and a little noise with stray frame starts
   task automatic queue_frames(input int count);
      int n, len, kind;
      logic fs_first;
      n = 0;
      while (n < count) begin
         kind     = $urandom_range(0, 99);
         len      = NUM_BINS;
         fs_first = 1'b1;
         if (kind < 8) begin
            len = $urandom_range(1, 40);
         end else if (kind < 14) begin
            fs_first = 1'b0;
         end else if (kind < 18) begin
            len = $urandom_range(1, 5);
            for (int b = 0; b < len && n < count; b++) begin
               queue_bin(pick_magnitude(), 1'($urandom_range(0, 1)));
               n++;
            end
            continue;
         end
         for (int b = 0; b < len && n < count; b++) begin
            queue_bin(pick_magnitude(), (b == 0) && fs_first);
            n++;
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every queued word went in and every height came back
   task automatic drain();
      while (bins_to_send.size() != 0 || req_bus.valid || heights_due.size() != 0)
         @(posedge clock);
   endtask

   // stimulus sequence
   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // reset settings: magnitude extremes, negatives, restart mid-frame
      queue_bin(16'sh7FFF, 1'b1);
      queue_bin(16'sh7FFF, 1'b0);
      queue_bin(-16'sh8000, 1'b0);
      queue_bin(-16'sh0001, 1'b0);
      queue_bin(16'sh0000, 1'b0);
      queue_bin(16'sh0001, 1'b0);
      queue_bin(16'sh5555, 1'b0);
      queue_bin(16'sh2AAA, 1'b0);
      queue_bin(16'sh7FFF, 1'b1);
      queue_bin(16'sh0000, 1'b0);
      queue_bin(16'sh4000, 1'b1);
      queue_bin(16'sh7FFF, 1'b0);
      // one whole frame, then run past the last bin without a frame start
      for (int b = 0; b < NUM_BINS; b++) queue_bin(pick_magnitude(), b == 0);
      for (int b = 0; b < 3; b++) queue_bin(pick_magnitude(), 1'b0);
      queue_frames(200);
      drain();

      // smallest knee, largest gain: levels saturate
      write_reg(CSR_LOG_KNEE, 16'd1);
      write_reg(CSR_LOG_GAIN, 16'hFFFF);
      queue_bin(16'sh7FFF, 1'b1);
      queue_bin(16'sh7FFF, 1'b0);
      queue_bin(-16'sh0001, 1'b0);
      queue_bin(16'sh0001, 1'b0);
      queue_frames(260);
      hold_arm = 1'b1;
      drain();

      // largest knee, zero gain: levels are zero
      write_reg(CSR_LOG_KNEE, 16'hFFFF);
      write_reg(CSR_LOG_GAIN, 16'd0);
      queue_frames(150);
      drain();

      // zero knee counts as one
      write_reg(CSR_LOG_KNEE, 16'd0);
      write_reg(CSR_LOG_GAIN, 16'd40000);
      queue_bin(16'sh0000, 1'b1);
      queue_bin(16'sh0001, 1'b0);
      queue_bin(16'sh7FFF, 1'b0);
      queue_frames(200);
      drain();

      // random settings
      for (int r = 0; r < 2; r++) begin
         write_reg(CSR_LOG_KNEE, CSR_DATA_W'($urandom_range(1, 65535)));
         write_reg(CSR_LOG_GAIN, CSR_DATA_W'($urandom));
         queue_frames(240);
         drain();
      end

      // back to the default curve, no idling on either side
      write_reg(CSR_LOG_KNEE, KNEE_RESET);
      write_reg(CSR_LOG_GAIN, GAIN_RESET);
      idle_en = 1'b0;
      queue_frames(150);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ files.f @@
hdl/lsbs_pkg.sv
hdl/lsbs_ifs.sv
hdl/log_spectrum_bar_smoother_top.sv
sim/tb_log_spectrum_bar_smoother_top.sv
